// ===== hw/rtl/u16dec_pkg.sv =====
// ----------------------------------------------------------------------------
// u16dec_pkg
// Shared types and constants for the UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u16dec_pkg;

  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [15:0] SURR_MASK  = 16'hFC00;
  localparam logic [15:0] HIGH_BASE  = 16'hD800;
  localparam logic [15:0] LOW_BASE   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [15:0] SHOW_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_LONE_LOW       = 2'd1,
    ST_UNPAIRED_HIGH  = 2'd2,
    ST_ENDED_MID_PAIR = 2'd3
  } status_t;

  // One classified code unit as it waits between front and back.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        eos;
    logic        is_high;
    logic        is_low;
  } item_t;

endpackage

// ===== hw/rtl/u16dec_front.sv =====
// ----------------------------------------------------------------------------
// u16dec_front
// Accepts code units and tags them as high surrogate, low surrogate or plain.
// ----------------------------------------------------------------------------
module u16dec_front (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // [15:0] code_unit
  input  logic                 s_axis_tlast,   // end_of_string
  output logic                 push,
  output u16dec_pkg::item_t    push_item,
  input  logic                 queue_full
);

  assign s_axis_tready = !queue_full;
  assign push          = s_axis_tvalid && !queue_full;

  always_comb begin
    push_item.code_unit = s_axis_tdata;
    push_item.eos       = s_axis_tlast;
    push_item.is_high   = (s_axis_tdata & u16dec_pkg::SURR_MASK) == u16dec_pkg::HIGH_BASE;
    push_item.is_low    = (s_axis_tdata & u16dec_pkg::SURR_MASK) == u16dec_pkg::LOW_BASE;
  end

endmodule

// ===== hw/rtl/u16dec_queue.sv =====
// ----------------------------------------------------------------------------
// u16dec_queue
// Small first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module u16dec_queue #(
  parameter int DEPTH = u16dec_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u16dec_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output u16dec_pkg::item_t pop_item,
  output logic              empty
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  u16dec_pkg::item_t entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = fill == CNT_W'(DEPTH);
  assign empty    = fill == '0;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("queue read while empty");
  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (empty && !push) |=> empty)
    else $error("queue became non-empty without a write");

endmodule

// ===== hw/rtl/u16dec_back.sv =====
// ----------------------------------------------------------------------------
// u16dec_back
// Pairs surrogates, keeps the per-string codepoint count and holds results.
// ----------------------------------------------------------------------------
module u16dec_back #(
  parameter int COUNT_BITS = u16dec_pkg::COUNT_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              queue_empty,
  input  u16dec_pkg::item_t head,
  output logic              pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [39:0]       m_axis_tdata,   // [20:0] codepoint, [36:21] char_count, rest 0
  output logic [1:0]        m_axis_tuser,   // [1:0] status
  output logic              m_axis_tlast    // last
);

  logic                  pending_valid;
  logic [9:0]            pending_high_bits;
  logic [COUNT_BITS-1:0] count;

  logic                  pending_valid_next;
  logic [9:0]            pending_high_bits_next;
  logic [COUNT_BITS-1:0] count_next;

  logic [20:0]           out_cp;
  u16dec_pkg::status_t   out_status;
  logic                  out_last;
  logic [15:0]           out_count;

  logic                  produce;
  logic                  bump;
  logic [20:0]           res_cp;
  u16dec_pkg::status_t   res_status;
  logic [COUNT_BITS-1:0] count_after;
  logic [31:0]           count_wide;
  logic [15:0]           res_count;

  assign pop = !queue_empty && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    produce                = 1'b1;
    bump                   = 1'b0;
    res_cp                 = '0;
    res_status             = u16dec_pkg::ST_OK;
    pending_valid_next     = pending_valid;
    pending_high_bits_next = pending_high_bits;

    if (pending_valid) begin
      if (head.is_low) begin
        res_cp = u16dec_pkg::SUPP_BASE + {1'b0, pending_high_bits, head.code_unit[9:0]};
        bump   = 1'b1;
      end else begin
        res_status = u16dec_pkg::ST_UNPAIRED_HIGH;
      end
      pending_valid_next     = 1'b0;
      pending_high_bits_next = '0;
    end else if (head.is_high) begin
      if (head.eos) begin
        res_status = u16dec_pkg::ST_ENDED_MID_PAIR;
      end else begin
        produce                = 1'b0;
        pending_valid_next     = 1'b1;
        pending_high_bits_next = head.code_unit[9:0];
      end
    end else if (head.is_low) begin
      res_status = u16dec_pkg::ST_LONE_LOW;
    end else begin
      res_cp = {5'b0, head.code_unit};
      bump   = 1'b1;
    end

    count_after = (bump && (count != {COUNT_BITS{1'b1}})) ? count + 1'b1 : count;
    count_wide  = 32'(count_after);
    res_count   = (count_wide > 32'(u16dec_pkg::SHOW_MAX)) ? u16dec_pkg::SHOW_MAX
                                                           : count_wide[15:0];
    count_next  = count_after;

    if (head.eos) begin
      count_next             = '0;
      pending_valid_next     = 1'b0;
      pending_high_bits_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid     <= 1'b0;
      pending_high_bits <= '0;
      count             <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (pop) begin
        pending_valid     <= pending_valid_next;
        pending_high_bits <= pending_high_bits_next;
        count             <= count_next;
        m_axis_tvalid     <= produce;
      end else if (m_axis_tready) begin
        m_axis_tvalid     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      out_cp     <= res_cp;
      out_status <= res_status;
      out_last   <= head.eos;
      out_count  <= res_count;
    end
  end

  assign m_axis_tdata = {3'b0, out_count, out_cp};
  assign m_axis_tuser = out_status;
  assign m_axis_tlast = out_last;

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.eos) |=> (!pending_valid && count == '0))
    else $error("string end left state behind");
  a_hold_no_result: assert property (@(posedge clk) disable iff (rst)
    (pop && !pending_valid && head.is_high && !head.eos) |=> (pending_valid && !m_axis_tvalid))
    else $error("held high surrogate produced a result");
  a_mid_pair_last: assert property (@(posedge clk) disable iff (rst)
    (pop && produce && res_status == u16dec_pkg::ST_ENDED_MID_PAIR) |-> head.eos)
    else $error("mid-pair end without string end");
  a_error_zero_cp: assert property (@(posedge clk) disable iff (rst)
    (pop && produce && res_status != u16dec_pkg::ST_OK) |=> (m_axis_tdata[20:0] == '0))
    else $error("error result carries a codepoint");

endmodule

// ===== hw/rtl/utf16_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf16_stream_decoder
// Decodes a stream of UTF-16 code units into Unicode codepoints.
//
//   port group   dir   tdata                         tuser        tlast
//   s_axis       in    [15:0] code_unit              -            end_of_string
//   m_axis       out   [20:0] codepoint,             [1:0] status last
//                      [36:21] char_count
//
// One code unit is taken per cycle unless the queue is full; a result passes
// through the queue, then the output register. A high surrogate that opens a
// pair yields no result of its own. Synchronous reset empties the queue,
// drops the output, clears the held surrogate and count. The front stalls only
// when the four-entry queue is full; the back stalls only on m_axis_tready.
// ----------------------------------------------------------------------------
module utf16_stream_decoder #(
  parameter int COUNT_BITS = u16dec_pkg::COUNT_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [20:0] codepoint, [36:21] char_count, rest 0
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last
);

  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_empty;
  u16dec_pkg::item_t push_item;
  u16dec_pkg::item_t head;

  u16dec_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .push          (push),
    .push_item     (push_item),
    .queue_full    (queue_full)
  );

  u16dec_queue #(
    .DEPTH (u16dec_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (head),
    .empty     (queue_empty)
  );

  u16dec_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .head          (head),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-16 stream decoder. A driver sends code units
// in bursts with random gaps, while the receiver stalls on a pattern that
// changes from time to time. Each accepted unit goes through a predictor that
// tracks the held high surrogate and the per-string codepoint count. Its
// results are queued and compared field by field with what the block returns.
// Stimulus covers a directed set of boundary and error cases. After that come
// random strings, made mostly of well-formed units and pairs, with broken
// pairs and stray surrogates mixed in.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] cu;
    logic        eos;
  } unit_item_t;

  typedef struct packed {
    logic [20:0]         cp;
    u16dec_pkg::status_t st;
    logic                last;
    logic [15:0]         cnt;
  } cp_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  unit_item_t units_q[$];
  cp_result_t cp_expect_q[$];
  int         mismatches = 0;

  // Predictor state.
  logic [9:0]  held_hi_bits = '0;
  logic        hi_held = 1'b0;
  logic [15:0] str_count = '0;

  // Driver pacing.
  int burst_left = 0;
  int gap_left = 0;

  // Receiver stall pattern.
  int       stall_mode = 0;
  int       stall_span = 0;
  bit [7:0] stall_pat = 8'hFF;

  utf16_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic add_unit(input logic [15:0] cu, input logic eos);
    unit_item_t it;
    it.cu = cu;
    it.eos = eos;
    units_q.push_back(it);
  endtask

  // Any codepoint of the basic plane outside the surrogate range.
  function automatic logic [15:0] rand_bmp();
    logic [15:0] r;
    r = 16'($urandom_range(0, 16'hF7FF));
    if (r >= u16dec_pkg::HIGH_BASE) r = r + 16'h0800;
    return r;
  endfunction

  task automatic decode_unit(input unit_item_t it);
    logic       is_hi;
    logic       is_lo;
    logic       gives;
    cp_result_t r;
    is_hi = (it.cu & u16dec_pkg::SURR_MASK) == u16dec_pkg::HIGH_BASE;
    is_lo = (it.cu & u16dec_pkg::SURR_MASK) == u16dec_pkg::LOW_BASE;
    gives = 1'b1;
    r = '0;
    r.last = it.eos;
    if (hi_held) begin
      if (is_lo) begin
        if (str_count != u16dec_pkg::SHOW_MAX) str_count = str_count + 16'd1;
        r.cp = u16dec_pkg::SUPP_BASE + {1'b0, held_hi_bits, it.cu[9:0]};
        r.st = u16dec_pkg::ST_OK;
      end else begin
        // The breaking unit is swallowed together with the held surrogate.
        r.st = u16dec_pkg::ST_UNPAIRED_HIGH;
      end
      hi_held = 1'b0;
      held_hi_bits = '0;
    end else if (is_hi) begin
      if (it.eos) begin
        r.st = u16dec_pkg::ST_ENDED_MID_PAIR;
      end else begin
        held_hi_bits = it.cu[9:0];
        hi_held = 1'b1;
        gives = 1'b0;
      end
    end else if (is_lo) begin
      r.st = u16dec_pkg::ST_LONE_LOW;
    end else begin
      if (str_count != u16dec_pkg::SHOW_MAX) str_count = str_count + 16'd1;
      r.cp = {5'b0, it.cu};
      r.st = u16dec_pkg::ST_OK;
    end
    r.cnt = str_count;
    if (gives) cp_expect_q.push_back(r);
    if (it.eos) begin
      str_count = '0;
      hi_held = 1'b0;
      held_hi_bits = '0;
    end
  endtask

  // Driver: holds an item until it is taken, then paces the next one.
  always @(posedge clk) begin : drive_p
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_unit(units_q[0]);
        units_q.delete(0);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || units_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= units_q[0].cu;
          s_axis_tlast  <= units_q[0].eos;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 9))
              0, 1: begin
                burst_left = $urandom_range(100, 400);
                gap_left = 0;
              end
              2: begin
                burst_left = $urandom_range(1, 8);
                gap_left = $urandom_range(10, 30);
              end
              default: begin
                burst_left = $urandom_range(1, 16);
                gap_left = $urandom_range(1, 5);
              end
            endcase
          end
        end
      end
    end
  end

  // Receiver: switches between always ready, random, sparse and a rotating mask.
  always @(posedge clk) begin : recv_p
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_span = $urandom_range(16, 300);
        stall_pat = 8'($urandom_range(0, 255)) | 8'h01;
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= 1'($urandom_range(0, 1));
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: begin
          m_axis_tready <= stall_pat[0];
          stall_pat = {stall_pat[0], stall_pat[7:1]};
        end
      endcase
    end
  end

  always @(posedge clk) begin : watch_p
    cp_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (cp_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: cp=%h st=%0d last=%b cnt=%0d",
                   m_axis_tdata[20:0], m_axis_tuser, m_axis_tlast, m_axis_tdata[36:21]);
      end else begin
        want = cp_expect_q.pop_front();
        if (m_axis_tdata[20:0] !== want.cp || m_axis_tuser !== want.st ||
            m_axis_tlast !== want.last || m_axis_tdata[36:21] !== want.cnt ||
            m_axis_tdata[39:37] !== 3'b000) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: want cp=%h st=%0d last=%b cnt=%0d, ",
                      "got cp=%h st=%0d last=%b cnt=%0d pad=%b"},
                     want.cp, want.st, want.last, want.cnt,
                     m_axis_tdata[20:0], m_axis_tuser, m_axis_tlast,
                     m_axis_tdata[36:21], m_axis_tdata[39:37]);
        end
      end
    end
  end

  initial begin : stim_p
    int          rand_units;
    int          len;
    int          pick;
    int          k;
    logic [15:0] u;
    logic        eos;

    // Boundaries of the basic plane on either side of the surrogates.
    add_unit(16'h0000, 1'b0);
    add_unit(16'hFFFF, 1'b0);
    add_unit(16'hD7FF, 1'b0);
    add_unit(16'hE000, 1'b0);
    // Lowest and highest supplementary codepoints.
    add_unit(16'hD800, 1'b0);
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hDFFF, 1'b0);
    // Stray low surrogates.
    add_unit(16'hDC00, 1'b0);
    add_unit(16'hDFFF, 1'b0);
    // A high surrogate broken by a plain unit, then by another high surrogate.
    add_unit(16'hD800, 1'b0);
    add_unit(16'h0041, 1'b0);
    add_unit(16'hDBFF, 1'b0);
    add_unit(16'hD800, 1'b0);
    // A pair that closes the string.
    add_unit(16'hDA12, 1'b0);
    add_unit(16'hDE34, 1'b1);
    // String that ends right after a high surrogate.
    add_unit(16'hD9AB, 1'b1);
    // Stray low surrogate as the last unit.
    add_unit(16'hDD00, 1'b1);
    // Broken pair on the last unit.
    add_unit(16'hDB00, 1'b0);
    add_unit(16'h0041, 1'b1);
    add_unit(16'h1234, 1'b1);

    rand_units = 0;
    while (rand_units < 880) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (k = 0; k < len; k++) begin
        eos = (k == len - 1);
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          u = rand_bmp();
        end else if (pick < 85) begin
          add_unit(u16dec_pkg::HIGH_BASE | 16'($urandom_range(0, 1023)), 1'b0);
          rand_units++;
          u = u16dec_pkg::LOW_BASE | 16'($urandom_range(0, 1023));
        end else if (pick < 92) begin
          u = 16'($urandom_range(0, 16'hFFFF));
        end else if (pick < 96) begin
          u = u16dec_pkg::LOW_BASE | 16'($urandom_range(0, 1023));
        end else begin
          // A high surrogate with whatever comes next, or the string end.
          u = u16dec_pkg::HIGH_BASE | 16'($urandom_range(0, 1023));
        end
        add_unit(u, eos);
        rand_units++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (units_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (cp_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && cp_expect_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog_p
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/u16dec_pkg.sv
hw/rtl/u16dec_front.sv
hw/rtl/u16dec_queue.sv
hw/rtl/u16dec_back.sv
hw/rtl/utf16_stream_decoder.sv
bench/tb_top.sv
